@@ rtl/hee_pkg.sv @@
// shared types, constants and byte tables for the html-escaping utf-8 encoder
// no dependencies; used by hee_front, hee_queue, hee_back and the top level
`default_nettype none

package hee_pkg;

  localparam int unsigned CP_W        = 21;
  localparam int unsigned IDX_W       = 3;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [CP_W-1:0] CP_MAX_1B = 21'h00007f;
  localparam logic [CP_W-1:0] CP_MAX_2B = 21'h0007ff;
  localparam logic [CP_W-1:0] CP_MAX_3B = 21'h00ffff;
  localparam logic [CP_W-1:0] CP_MAX    = 21'h10ffff;

  localparam logic [CP_W-1:0] CP_AMP  = 21'h000026;
  localparam logic [CP_W-1:0] CP_QUOT = 21'h000022;
  localparam logic [CP_W-1:0] CP_APOS = 21'h000027;
  localparam logic [CP_W-1:0] CP_LT   = 21'h00003c;
  localparam logic [CP_W-1:0] CP_GT   = 21'h00003e;

  localparam logic [7:0] LEAD_2B = 8'hc0;
  localparam logic [7:0] LEAD_3B = 8'he0;
  localparam logic [7:0] LEAD_4B = 8'hf0;
  localparam logic [7:0] CONT_B  = 8'h80;

  // item classes decided by the front
  typedef enum logic [3:0] {
    K_U1,
    K_U2,
    K_U3,
    K_U4,
    K_AMP,
    K_QUOT,
    K_APOS,
    K_LT,
    K_GT,
    K_NONE
  } kind_t;

  // one classified item as it sits in the queue
  typedef struct packed {
    kind_t           kind;
    logic [CP_W-1:0] cp;
    logic            send;
  } item_t;

  // number of results an item class produces
  function automatic logic [IDX_W-1:0] result_count(input kind_t kind);
    logic [IDX_W-1:0] n;
    unique case (kind)
      K_U1:           n = 3'd1;
      K_U2:           n = 3'd2;
      K_U3:           n = 3'd3;
      K_U4:           n = 3'd4;
      K_AMP:          n = 3'd5;
      K_QUOT, K_APOS: n = 3'd6;
      K_LT, K_GT:     n = 3'd4;
      default:        n = 3'd1;
    endcase
    return n;
  endfunction

  // byte number idx of an item
  function automatic logic [7:0] result_byte(input kind_t kind, input logic [CP_W-1:0] cp,
                                             input logic [IDX_W-1:0] idx);
    logic [7:0] b;
    b = 8'h00;
    unique case (kind)
      K_U1: b = {1'b0, cp[6:0]};
      K_U2: begin
        case (idx)
          3'd0:    b = LEAD_2B | {3'b000, cp[10:6]};
          default: b = CONT_B | {2'b00, cp[5:0]};
        endcase
      end
      K_U3: begin
        case (idx)
          3'd0:    b = LEAD_3B | {4'b0000, cp[15:12]};
          3'd1:    b = CONT_B | {2'b00, cp[11:6]};
          default: b = CONT_B | {2'b00, cp[5:0]};
        endcase
      end
      K_U4: begin
        case (idx)
          3'd0:    b = LEAD_4B | {5'b00000, cp[20:18]};
          3'd1:    b = CONT_B | {2'b00, cp[17:12]};
          3'd2:    b = CONT_B | {2'b00, cp[11:6]};
          default: b = CONT_B | {2'b00, cp[5:0]};
        endcase
      end
      // &amp;
      K_AMP: begin
        case (idx)
          3'd0:    b = 8'h26;
          3'd1:    b = 8'h61;
          3'd2:    b = 8'h6d;
          3'd3:    b = 8'h70;
          default: b = 8'h3b;
        endcase
      end
      // &quot;
      K_QUOT: begin
        case (idx)
          3'd0:    b = 8'h26;
          3'd1:    b = 8'h71;
          3'd2:    b = 8'h75;
          3'd3:    b = 8'h6f;
          3'd4:    b = 8'h74;
          default: b = 8'h3b;
        endcase
      end
      // &apos;
      K_APOS: begin
        case (idx)
          3'd0:    b = 8'h26;
          3'd1:    b = 8'h61;
          3'd2:    b = 8'h70;
          3'd3:    b = 8'h6f;
          3'd4:    b = 8'h73;
          default: b = 8'h3b;
        endcase
      end
      // &lt;
      K_LT: begin
        case (idx)
          3'd0:    b = 8'h26;
          3'd1:    b = 8'h6c;
          3'd2:    b = 8'h74;
          default: b = 8'h3b;
        endcase
      end
      // &gt;
      K_GT: begin
        case (idx)
          3'd0:    b = 8'h26;
          3'd1:    b = 8'h67;
          3'd2:    b = 8'h74;
          default: b = 8'h3b;
        endcase
      end
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

@@ rtl/html_escaping_utf8_encoder.sv @@
// html-escaping utf-8 encoder: one code point in, its entity, its utf-8 bytes or a no-byte marker out
// path: an accepted code point passes the item queue and the current-item register into the result register
// throughput: one result per cycle unless the sequencer holds no item or a full result register waits for pop;
// an item has 1 to 6 results, written by the back-end sequencer one byte per cycle into the result register
// reset: synchronous rst empties the item queue and the result register
// depends on hee_pkg, hee_front, hee_queue, hee_back
`default_nettype none

module html_escaping_utf8_encoder #(
  parameter int unsigned QDEPTH = hee_pkg::QUEUE_DEPTH
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     push,
  output logic                          full,
  input  wire logic [hee_pkg::CP_W-1:0] code_point,
  input  wire logic                     string_end,
  output logic                          empty,
  input  wire logic                     pop,
  output logic [7:0]                    out_byte,
  output logic                          byte_valid,
  output logic                          last_of_item,
  output logic                          string_end_out
);

  logic           q_full;
  logic           q_push;
  logic           q_empty;
  logic           q_pop;
  hee_pkg::item_t q_wdata;
  hee_pkg::item_t q_rdata;

  hee_front u_front (
    .push       (push),
    .full       (full),
    .code_point (code_point),
    .string_end (string_end),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_item     (q_wdata)
  );

  hee_queue #(
    .QDEPTH (QDEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  hee_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_item         (q_rdata),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .out_byte       (out_byte),
    .byte_valid     (byte_valid),
    .last_of_item   (last_of_item),
    .string_end_out (string_end_out),
    .empty          (empty),
    .pop            (pop)
  );

  // an empty marker result always closes its item
  a_marker_is_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && !byte_valid) |-> last_of_item)
    else $error("marker result without last_of_item");

  // end-of-string only rides on the last result of an item
  a_send_on_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && string_end_out) |-> last_of_item)
    else $error("string_end_out on a result that is not last");

  // reset leaves no result waiting
  a_reset_empty: assert property (@(posedge clk)
    rst |=> empty)
    else $error("result pending after reset");

endmodule

`default_nettype wire

@@ rtl/hee_front.sv @@
// front end: takes code points and classifies them into entity, utf-8 or no-byte classes
// depends on hee_pkg
`default_nettype none

module hee_front (
  input  wire logic                     push,
  output logic                          full,
  input  wire logic [hee_pkg::CP_W-1:0] code_point,
  input  wire logic                     string_end,
  input  wire logic                     q_full,
  output logic                          q_push,
  output hee_pkg::item_t                q_item
);

  hee_pkg::kind_t kind;

  // classify the incoming code point
  always_comb begin
    if (code_point == hee_pkg::CP_AMP) begin
      kind = hee_pkg::K_AMP;
    end else if (code_point == hee_pkg::CP_QUOT) begin
      kind = hee_pkg::K_QUOT;
    end else if (code_point == hee_pkg::CP_APOS) begin
      kind = hee_pkg::K_APOS;
    end else if (code_point == hee_pkg::CP_LT) begin
      kind = hee_pkg::K_LT;
    end else if (code_point == hee_pkg::CP_GT) begin
      kind = hee_pkg::K_GT;
    end else if (code_point <= hee_pkg::CP_MAX_1B) begin
      kind = hee_pkg::K_U1;
    end else if (code_point <= hee_pkg::CP_MAX_2B) begin
      kind = hee_pkg::K_U2;
    end else if (code_point <= hee_pkg::CP_MAX_3B) begin
      kind = hee_pkg::K_U3;
    end else if (code_point <= hee_pkg::CP_MAX) begin
      kind = hee_pkg::K_U4;
    end else begin
      kind = hee_pkg::K_NONE;
    end
  end

  // input transfer writes straight into the queue
  assign full        = q_full;
  assign q_push      = push & ~q_full;
  assign q_item.kind = kind;
  assign q_item.cp   = code_point;
  assign q_item.send = string_end;

endmodule

`default_nettype wire

@@ rtl/hee_queue.sv @@
// short fifo of classified items between front and back
// depends on hee_pkg
`default_nettype none

module hee_queue #(
  parameter int unsigned QDEPTH = hee_pkg::QUEUE_DEPTH
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  hee_pkg::item_t      wdata,
  output logic                full,
  input  wire logic           pop,
  output hee_pkg::item_t      rdata,
  output logic                empty
);

  localparam int unsigned PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QDEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QDEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QDEPTH);

  hee_pkg::item_t   mem [QDEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_FULL);
  assign empty   = (count == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rdata   = mem[rptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PTR_LAST) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PTR_LAST) ? '0 : rptr + 1'b1;
      end
      if (do_push & ~do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop & ~do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/hee_back.sv @@
// back end: walks one item's bytes, one per cycle while the result register is free or popped, into the result register
// depends on hee_pkg
`default_nettype none

module hee_back (
  input  wire logic       clk,
  input  wire logic       rst,
  input  hee_pkg::item_t  q_item,
  input  wire logic       q_empty,
  output logic            q_pop,
  output logic [7:0]      out_byte,
  output logic            byte_valid,
  output logic            last_of_item,
  output logic            string_end_out,
  output logic            empty,
  input  wire logic       pop
);

  hee_pkg::item_t              cur;
  logic                        busy;
  logic [hee_pkg::IDX_W-1:0]   idx;
  logic [hee_pkg::IDX_W-1:0]   cnt;
  logic                        out_full;
  logic                        out_load;
  logic                        is_last;
  logic                        take;

  // sequencer control
  always_comb begin
    cnt      = hee_pkg::result_count(cur.kind);
    is_last  = (idx == cnt - 1'b1);
    out_load = busy & (~out_full | pop);
    take     = ~q_empty & (~busy | (out_load & is_last));
  end

  assign q_pop = take;
  assign empty = ~out_full;

  // current item and byte index
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else begin
      if (take) begin
        busy <= 1'b1;
        idx  <= '0;
      end else begin
        if (out_load & is_last) begin
          busy <= 1'b0;
        end
        if (out_load) begin
          idx <= idx + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur <= q_item;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else begin
      out_full <= out_load | (out_full & ~pop);
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_byte       <= hee_pkg::result_byte(cur.kind, cur.cp, idx);
      byte_valid     <= (cur.kind != hee_pkg::K_NONE);
      last_of_item   <= is_last;
      string_end_out <= is_last & cur.send;
    end
  end

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
// self-checking testbench for the html-escaping utf-8 encoder
// depends on rtl/hee_pkg.sv and rtl/html_escaping_utf8_encoder.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int N_RANDOM   = 286;
  localparam int DRAIN_CYC  = 8;
  localparam int STALL_LIMIT = 4000;
  localparam int CP_BITS    = hee_pkg::CP_W;

  // idling phases
  localparam int PH_NONE = 0;
  localparam int PH_SEND = 1;
  localparam int PH_RECV = 2;
  localparam int PH_BOTH = 3;

  // one code point to send, with an optional typed-in expectation
  typedef struct {
    logic [hee_pkg::CP_W-1:0] cp;
    logic                     send;
    int                       phase;
    bit                       typed;
    int                       nbytes;   // 0 marks the no-byte result
    logic [47:0]              bytes;    // byte 0 in the top eight bits
  } cp_item_t;

  // one expected output byte
  typedef struct {
    logic [7:0] data;
    logic       valid;
    logic       last;
    logic       send;
  } out_byte_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     push = 1'b0;
  logic                     pop = 1'b0;
  logic [hee_pkg::CP_W-1:0] code_point = '0;
  logic                     string_end = 1'b0;
  logic                     full;
  logic                     empty;
  logic [7:0]               out_byte;
  logic                     byte_valid;
  logic                     last_of_item;
  logic                     string_end_out;

  cp_item_t  cp_table[$];
  cp_item_t  code_point_q[$];
  out_byte_t owed_bytes[$];
  int        err_count = 0;
  int        cur_phase = PH_NONE;
  int        stall_cnt = 0;

  html_escaping_utf8_encoder dut (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .code_point     (code_point),
    .string_end     (string_end),
    .empty          (empty),
    .pop            (pop),
    .out_byte       (out_byte),
    .byte_valid     (byte_valid),
    .last_of_item   (last_of_item),
    .string_end_out (string_end_out)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // bytes of one code point: entity text, utf-8, or none above the range
  function automatic int encode_cp(input logic [hee_pkg::CP_W-1:0] cp,
                                   output logic [47:0] bytes);
    logic [31:0] v;
    int          n;
    v = {11'd0, cp};
    bytes = '0;
    n = 0;
    if (cp == hee_pkg::CP_AMP) begin
      bytes = 48'h26616d703b00;
      n = 5;
    end else if (cp == hee_pkg::CP_QUOT) begin
      bytes = 48'h2671756f743b;
      n = 6;
    end else if (cp == hee_pkg::CP_APOS) begin
      bytes = 48'h2661706f733b;
      n = 6;
    end else if (cp == hee_pkg::CP_LT) begin
      bytes = 48'h266c743b0000;
      n = 4;
    end else if (cp == hee_pkg::CP_GT) begin
      bytes = 48'h2667743b0000;
      n = 4;
    end else if (cp <= hee_pkg::CP_MAX_1B) begin
      bytes[47:40] = v[7:0];
      n = 1;
    end else if (cp <= hee_pkg::CP_MAX_2B) begin
      bytes[47:40] = hee_pkg::LEAD_2B + v[13:6];
      bytes[39:32] = hee_pkg::CONT_B + {2'b00, v[5:0]};
      n = 2;
    end else if (cp <= hee_pkg::CP_MAX_3B) begin
      bytes[47:40] = hee_pkg::LEAD_3B + v[19:12];
      bytes[39:32] = hee_pkg::CONT_B + {2'b00, v[11:6]};
      bytes[31:24] = hee_pkg::CONT_B + {2'b00, v[5:0]};
      n = 3;
    end else if (cp <= hee_pkg::CP_MAX) begin
      bytes[47:40] = hee_pkg::LEAD_4B + v[25:18];
      bytes[39:32] = hee_pkg::CONT_B + {2'b00, v[17:12]};
      bytes[31:24] = hee_pkg::CONT_B + {2'b00, v[11:6]};
      bytes[23:16] = hee_pkg::CONT_B + {2'b00, v[5:0]};
      n = 4;
    end
    return n;
  endfunction

  // queue the output bytes owed for one accepted code point
  task automatic owe_bytes(input int n, input logic [47:0] bytes, input logic send);
    out_byte_t r;
    if (n == 0) begin
      r = '{8'h00, 1'b0, 1'b1, send};
      owed_bytes.push_back(r);
    end else begin
      for (int k = 0; k < n; k++) begin
        r.data  = bytes[47-8*k -: 8];
        r.valid = 1'b1;
        r.last  = (k == n - 1);
        r.send  = (k == n - 1) ? send : 1'b0;
        owed_bytes.push_back(r);
      end
    end
  endtask

  task automatic add_row(input logic [hee_pkg::CP_W-1:0] cp, input logic send,
                         input bit typed, input int n, input logic [47:0] bytes);
    cp_item_t it;
    it.cp     = cp;
    it.send   = send;
    it.phase  = PH_NONE;
    it.typed  = typed;
    it.nbytes = n;
    it.bytes  = bytes;
    cp_table.push_back(it);
  endtask

  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %h, actual %h", name, exp_v, act_v);
      err_count++;
    end
  endtask

  // random code point, weighted toward each encoding class and the entities
  function automatic logic [hee_pkg::CP_W-1:0] rand_cp();
    int sel;
    logic [hee_pkg::CP_W-1:0] cp;
    sel = $urandom_range(0, 99);
    if (sel < 18) begin
      case ($urandom_range(0, 4))
        0:       cp = hee_pkg::CP_AMP;
        1:       cp = hee_pkg::CP_QUOT;
        2:       cp = hee_pkg::CP_APOS;
        3:       cp = hee_pkg::CP_LT;
        default: cp = hee_pkg::CP_GT;
      endcase
    end else if (sel < 40) cp = CP_BITS'($urandom_range(0, 'h7f));
    else if (sel < 55) cp = CP_BITS'($urandom_range('h80, 'h7ff));
    else if (sel < 70) cp = CP_BITS'($urandom_range('h800, 'hffff));
    else if (sel < 77) cp = CP_BITS'($urandom_range('hd800, 'hdfff));
    else if (sel < 89) cp = CP_BITS'($urandom_range('h10000, 'h10ffff));
    else if (sel < 95) cp = CP_BITS'($urandom_range('h110000, 'h1fffff));
    else cp = CP_BITS'($urandom_range(0, 'h1fffff));
    return cp;
  endfunction

  // stimulus: directed table, then random strings
  initial begin
    cp_item_t it;
    int       i;
    int       len;
    // range extremes and encoding boundaries
    add_row(21'h000000, 1'b0, 1'b1, 1, 48'h000000000000);
    add_row(21'h00007f, 1'b1, 1'b1, 1, 48'h7f0000000000);
    add_row(21'h000080, 1'b0, 1'b1, 2, 48'hc28000000000);
    add_row(21'h0007ff, 1'b0, 1'b1, 2, 48'hdfbf00000000);
    add_row(21'h000800, 1'b0, 1'b1, 3, 48'he0a080000000);
    add_row(21'h00ffff, 1'b1, 1'b1, 3, 48'hefbfbf000000);
    add_row(21'h010000, 1'b0, 1'b1, 4, 48'hf09080800000);
    add_row(21'h10ffff, 1'b0, 1'b1, 4, 48'hf48fbfbf0000);
    // above the unicode range: marker result only
    add_row(21'h110000, 1'b0, 1'b1, 0, 48'h0);
    add_row(21'h1fffff, 1'b1, 1'b1, 0, 48'h0);
    // the five escaped characters
    add_row(hee_pkg::CP_AMP,  1'b0, 1'b1, 5, 48'h26616d703b00);
    add_row(hee_pkg::CP_QUOT, 1'b1, 1'b1, 6, 48'h2671756f743b);
    add_row(hee_pkg::CP_APOS, 1'b0, 1'b1, 6, 48'h2661706f733b);
    add_row(hee_pkg::CP_LT,   1'b0, 1'b1, 4, 48'h266c743b0000);
    add_row(hee_pkg::CP_GT,   1'b1, 1'b1, 4, 48'h2667743b0000);
    // surrogates pass as plain 3-byte sequences; neighbors of the entities and assorted multi-byte points
    add_row(21'h00d800, 1'b0, 1'b0, 0, 48'h0);
    add_row(21'h00dfff, 1'b1, 1'b0, 0, 48'h0);
    add_row(21'h000025, 1'b0, 1'b0, 0, 48'h0);
    add_row(21'h000028, 1'b0, 1'b0, 0, 48'h0);
    add_row(21'h00003d, 1'b0, 1'b0, 0, 48'h0);
    add_row(21'h00003b, 1'b1, 1'b0, 0, 48'h0);
    add_row(21'h0000e9, 1'b0, 1'b0, 0, 48'h0);
    add_row(21'h01f600, 1'b1, 1'b0, 0, 48'h0);
    add_row(21'h0fffff, 1'b0, 1'b0, 0, 48'h0);
    foreach (cp_table[r]) code_point_q.push_back(cp_table[r]);

    // random strings; the string end flag is flipped now and then
    i = 0;
    while (i < N_RANDOM) begin
      len = $urandom_range(1, 8);
      for (int k = 0; k < len && i < N_RANDOM; k++) begin
        it.cp     = rand_cp();
        it.send   = (k == len - 1);
        if ($urandom_range(0, 9) == 0) it.send = ~it.send;
        it.phase  = (i < 40) ? PH_NONE : 1 + (i - 40) * 3 / (N_RANDOM - 40);
        it.typed  = 1'b0;
        it.nbytes = 0;
        it.bytes  = '0;
        code_point_q.push_back(it);
        i++;
      end
    end
  end

  // sender, receiver and result checker
  always @(posedge clk) begin
    cp_item_t    cur;
    out_byte_t   exp_r;
    logic [47:0] bytes;
    int          n;
    int          send_pct;
    int          recv_pct;
    if (rst) begin
      push <= 1'b0;
      pop  <= 1'b0;
    end else begin
      // input transfer
      if (push && !full) begin
        cur = code_point_q.pop_front();
        if (cur.typed) begin
          n = cur.nbytes;
          bytes = cur.bytes;
        end else begin
          n = encode_cp(cur.cp, bytes);
        end
        owe_bytes(n, bytes, cur.send);
      end

      // result transfer
      if (pop && !empty) begin
        if (owed_bytes.size() == 0) begin
          $error("unexpected result: out_byte %h byte_valid %b", out_byte, byte_valid);
          err_count++;
        end else begin
          exp_r = owed_bytes.pop_front();
          check_field("out_byte", exp_r.data, out_byte);
          check_field("byte_valid", {7'd0, exp_r.valid}, {7'd0, byte_valid});
          check_field("last_of_item", {7'd0, exp_r.last}, {7'd0, last_of_item});
          check_field("string_end_out", {7'd0, exp_r.send}, {7'd0, string_end_out});
        end
      end

      send_pct = (cur_phase == PH_SEND) ? 54 : (cur_phase == PH_BOTH) ? 26 : 0;
      recv_pct = (cur_phase == PH_RECV) ? 54 : (cur_phase == PH_BOTH) ? 26 : 0;

      // next input: hold a refused one, else offer the next or idle
      if (push && full) begin
        push <= 1'b1;
      end else if (code_point_q.size() > 0 && $urandom_range(0, 99) >= send_pct) begin
        push       <= 1'b1;
        code_point <= code_point_q[0].cp;
        string_end <= code_point_q[0].send;
        cur_phase  <= code_point_q[0].phase;
      end else begin
        push <= 1'b0;
      end

      pop <= ($urandom_range(0, 99) >= recv_pct);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst) begin
      if ((push && !full) || (pop && !empty)) stall_cnt <= 0;
      else stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= STALL_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // reset, wait for all results, then report
  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    while (code_point_q.size() != 0 || push || owed_bytes.size() != 0) @(negedge clk);
    repeat (DRAIN_CYC) @(negedge clk);
    if (owed_bytes.size() != 0) begin
      $error("%0d expected results never arrived", owed_bytes.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
